// File: src/mtla_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the Morse tree LED animator.
package mtla_pkg;

  localparam int LED_COUNT = 64;
  localparam logic [5:0] ROOT_NODE = 6'd1;
  localparam int CFG_IDX_W = 3;

  localparam logic [3:0] ACT_SHOW     = 4'd0;
  localparam logic [3:0] ACT_SET_MODE = 4'd1;
  localparam logic [3:0] ACT_TOGGLE   = 4'd2;
  localparam logic [3:0] ACT_LOCK     = 4'd3;
  localparam logic [3:0] ACT_ERROR    = 4'd4;
  localparam logic [3:0] ACT_CANCEL   = 4'd5;
  localparam logic [3:0] ACT_RAW      = 4'd6;
  localparam logic [3:0] ACT_TICK     = 4'd7;
  localparam logic [3:0] ACT_LOAD     = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_STYLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_HALF    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_HALF     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_LEDS     = 3'd6;

  typedef enum logic [1:0] {
    ANIM_NONE  = 2'd0,
    ANIM_HOLD  = 2'd1,
    ANIM_BLINK = 2'd2,
    ANIM_ERR   = 2'd3
  } anim_t;

  typedef enum logic [1:0] {
    WSRC_ITEM = 2'd0,
    WSRC_CUR  = 2'd1,
    WSRC_ROOT = 2'd2,
    WSRC_ANIM = 2'd3
  } walk_src_t;

  typedef enum logic [1:0] {
    EMIT_FRAME = 2'd0,
    EMIT_BLINK = 2'd1,
    EMIT_RAW   = 2'd2
  } emit_sel_t;

  typedef struct packed {
    logic      capture;
    logic      op_show;
    logic      op_mode;
    logic      op_lock;
    logic      op_error;
    logic      op_idle;
    logic      op_end;
    logic      op_load;
    logic      walk_start;
    walk_src_t walk_src;
    logic      walk_single;
    logic      walk_rd;
    logic      walk_acc;
    logic      mul;
    logic      div_start;
    logic      div_step;
    logic      set_phase;
    logic      out_load;
    emit_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] action;
    anim_t      kind;
    logic       style_blink;
    logic       hold_over;
    logic       blink_over;
    logic       walk_skip;
    logic       walk_last;
    logic       div_last;
    logic       phase_same;
    logic       out_free;
  } dp_sts_t;

endpackage

// File: src/mtla_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and LED frames.
interface mtla_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [5:0]  node;
  logic        mode_path;
  logic [31:0] now_ms;
  logic [63:0] raw_bits;
  logic [5:0]  map_led;
  logic        map_has_led;

  modport source (
    output valid, action, node, mode_path, now_ms, raw_bits, map_led, map_has_led,
    input  ready
  );
  modport sink (
    input  valid, action, node, mode_path, now_ms, raw_bits, map_led, map_has_led,
    output ready
  );
endinterface

interface mtla_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] led_bits;

  modport source (output valid, led_bits, input ready);
  modport sink (input valid, led_bits, output ready);
endinterface

// File: src/mtla_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mtla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: src/mtla_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences each input beat through the datapath.
module mtla_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtla_pkg::dp_sts_t sts,
  output mtla_pkg::dp_cmd_t cmd
);
  import mtla_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_EXEC = 8'b0000_0010,
    ST_BCHK = 8'b0000_0100,
    ST_DIV  = 8'b0000_1000,
    ST_PCHK = 8'b0001_0000,
    ST_WRD  = 8'b0010_0000,
    ST_WACC = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_t;

  state_t    state_r, state_nxt;
  emit_sel_t emit_sel_r, emit_sel_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    emit_sel_nxt = emit_sel_r;
    cmd          = '0;
    cmd.emit_sel = emit_sel_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        emit_sel_nxt = EMIT_FRAME;
        state_nxt    = ST_IDLE;
        case (sts.action)
          ACT_SHOW: begin
            cmd.op_show    = 1'b1;
            cmd.walk_start = 1'b1;
            cmd.walk_src   = WSRC_ITEM;
            state_nxt      = ST_WRD;
          end
          ACT_SET_MODE, ACT_TOGGLE: begin
            cmd.op_mode = 1'b1;
            if (sts.kind == ANIM_NONE) begin
              cmd.walk_start = 1'b1;
              cmd.walk_src   = WSRC_CUR;
              state_nxt      = ST_WRD;
            end
          end
          ACT_LOCK: begin
            cmd.op_lock = 1'b1;
            if (!sts.style_blink) begin
              cmd.walk_start  = 1'b1;
              cmd.walk_src    = WSRC_ITEM;
              cmd.walk_single = 1'b1;
              state_nxt       = ST_WRD;
            end
          end
          ACT_ERROR: begin
            cmd.op_error = 1'b1;
          end
          ACT_CANCEL: begin
            cmd.op_idle = 1'b1;
          end
          ACT_RAW: begin
            cmd.op_idle  = 1'b1;
            emit_sel_nxt = EMIT_RAW;
            state_nxt    = ST_EMIT;
          end
          ACT_TICK: begin
            case (sts.kind)
              ANIM_HOLD: begin
                if (sts.hold_over) begin
                  cmd.op_end     = 1'b1;
                  cmd.walk_start = 1'b1;
                  cmd.walk_src   = WSRC_ROOT;
                  state_nxt      = ST_WRD;
                end
              end
              ANIM_BLINK, ANIM_ERR: begin
                cmd.mul   = 1'b1;
                state_nxt = ST_BCHK;
              end
              default: begin
                state_nxt = ST_IDLE;
              end
            endcase
          end
          ACT_LOAD: begin
            cmd.op_load = 1'b1;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_BCHK: begin
        if (sts.blink_over) begin
          cmd.op_end     = 1'b1;
          cmd.walk_start = 1'b1;
          cmd.walk_src   = WSRC_ROOT;
          state_nxt      = ST_WRD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_PCHK;
        end
      end
      ST_PCHK: begin
        if (sts.phase_same) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.set_phase = 1'b1;
          emit_sel_nxt  = EMIT_BLINK;
          if (sts.kind == ANIM_BLINK) begin
            cmd.walk_start  = 1'b1;
            cmd.walk_src    = WSRC_ANIM;
            cmd.walk_single = 1'b1;
            state_nxt       = ST_WRD;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_WRD: begin
        if (sts.walk_skip) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = ST_WACC;
        end
      end
      ST_WACC: begin
        cmd.walk_acc = 1'b1;
        state_nxt    = sts.walk_last ? ST_EMIT : ST_WRD;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      emit_sel_r <= EMIT_FRAME;
    end else begin
      state_r    <= state_nxt;
      emit_sel_r <= emit_sel_nxt;
    end
  end
endmodule

// File: src/mtla_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration, animation state, node map, path walker, divider and output.
module mtla_datapath #(
  parameter int NODE_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mtla_pkg::dp_cmd_t              cmd,
  output mtla_pkg::dp_sts_t              sts,
  input  logic [3:0]                     in_action,
  input  logic [5:0]                     in_node,
  input  logic                           in_mode_path,
  input  logic [31:0]                    in_now_ms,
  input  logic [63:0]                    in_raw_bits,
  input  logic [5:0]                     in_map_led,
  input  logic                           in_map_has_led,
  input  logic                           cfg_we,
  input  logic [mtla_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [63:0]                    cfg_wdata,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [63:0]                    out_led_bits
);
  import mtla_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  logic        style_r;
  logic [15:0] hold_r;
  logic [7:0]  lock_cnt_r;
  logic [15:0] lock_half_r;
  logic [7:0]  err_cnt_r;
  logic [15:0] err_half_r;
  logic [63:0] mask_r;

  logic [3:0]  act_r;
  logic [5:0]  node_r;
  logic        modep_r;
  logic [31:0] now_r;
  logic [63:0] raw_r;
  logic [5:0]  mled_r;
  logic        mhas_r;

  logic        mode_r, mode_nxt;
  logic [5:0]  cur_r;
  anim_t       kind_r;
  logic [5:0]  anode_r;
  logic [31:0] astart_r;
  logic [31:0] aphase_r;

  logic [5:0]  wnode_r, wsrc_node;
  logic        wsingle_r;
  logic [63:0] wacc_r;
  logic        rd_ok_r;
  logic [NODE_COUNT-1:0] map_vld_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        rd_in_range, wr_in_range, map_we;
  logic [6:0]  rd_data;
  logic        bit_ok;
  logic [63:0] led_mask;

  logic [24:0] total_r;
  logic [23:0] prod;
  logic [7:0]  count_sel;
  logic [15:0] half_sel;
  logic [31:0] elapsed;

  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [16:0] div_sh;
  logic [4:0]  dcnt_r;

  logic        out_valid_r;
  logic [63:0] out_bits_r;
  logic [63:0] emit_frame;

  assign elapsed   = now_r - astart_r;
  assign count_sel = (kind_r == ANIM_ERR) ? err_cnt_r : lock_cnt_r;
  assign half_sel  = (kind_r == ANIM_ERR) ? err_half_r : lock_half_r;
  assign prod      = 24'(count_sel) * 24'(half_sel);

  always_comb begin
    mode_nxt = mode_r;
    if (cmd.op_mode) begin
      mode_nxt = (act_r == ACT_SET_MODE) ? modep_r : ~mode_r;
    end
  end

  always_comb begin
    case (cmd.walk_src)
      WSRC_ITEM: wsrc_node = node_r;
      WSRC_CUR:  wsrc_node = cur_r;
      WSRC_ROOT: wsrc_node = ROOT_NODE;
      WSRC_ANIM: wsrc_node = anode_r;
      default:   wsrc_node = node_r;
    endcase
  end

  assign rd_addr     = AW'(wnode_r);
  assign rd_in_range = int'(wnode_r) < NODE_COUNT;
  assign wr_addr     = AW'(node_r);
  assign wr_in_range = int'(node_r) < NODE_COUNT;
  assign map_we      = cmd.op_load && wr_in_range;

  mtla_ram #(
    .WIDTH(7),
    .DEPTH(NODE_COUNT)
  ) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(wr_addr),
    .wdata({mhas_r, mled_r}),
    .re   (cmd.walk_rd),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign bit_ok   = rd_ok_r && rd_data[6] && (int'(rd_data[5:0]) < LED_COUNT);
  assign led_mask = bit_ok ? (64'd1 << rd_data[5:0]) : 64'd0;

  assign div_sh = {rem_r, quo_r[31]};
  always_comb begin
    if (div_sh >= {1'b0, half_sel}) begin
      rem_nxt = 16'(div_sh - {1'b0, half_sel});
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = div_sh[15:0];
      quo_nxt = {quo_r[30:0], 1'b0};
    end
  end

  always_comb begin
    case (cmd.emit_sel)
      EMIT_FRAME: emit_frame = wacc_r;
      EMIT_RAW:   emit_frame = raw_r;
      EMIT_BLINK: emit_frame = aphase_r[0] ? 64'd0 :
                               ((kind_r == ANIM_ERR) ? mask_r : wacc_r);
      default:    emit_frame = wacc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r     <= 1'b0;
      hold_r      <= 16'd500;
      lock_cnt_r  <= 8'd3;
      lock_half_r <= 16'd100;
      err_cnt_r   <= 8'd3;
      err_half_r  <= 16'd100;
      mask_r      <= '1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LOCK_STYLE: style_r     <= cfg_wdata[0];
        CFG_LOCK_HOLD:  hold_r      <= cfg_wdata[15:0];
        CFG_LOCK_COUNT: lock_cnt_r  <= cfg_wdata[7:0];
        CFG_LOCK_HALF:  lock_half_r <= cfg_wdata[15:0];
        CFG_ERR_COUNT:  err_cnt_r   <= cfg_wdata[7:0];
        CFG_ERR_HALF:   err_half_r  <= cfg_wdata[15:0];
        CFG_ALL_LEDS:   mask_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= in_action;
      node_r  <= in_node;
      modep_r <= in_mode_path;
      now_r   <= in_now_ms;
      raw_r   <= in_raw_bits;
      mled_r  <= in_map_led;
      mhas_r  <= in_map_has_led;
    end
    if (cmd.walk_start) begin
      wnode_r   <= wsrc_node;
      wsingle_r <= cmd.walk_single || !mode_nxt;
      wacc_r    <= 64'd0;
    end else if (cmd.walk_acc) begin
      wnode_r <= wnode_r >> 1;
      wacc_r  <= wacc_r | led_mask;
    end
    if (cmd.walk_rd) begin
      rd_ok_r <= rd_in_range && map_vld_r[rd_addr];
    end
    if (cmd.mul) begin
      total_r <= {prod, 1'b0};
    end
    if (cmd.div_start) begin
      quo_r  <= elapsed;
      rem_r  <= 16'd0;
      dcnt_r <= 5'd0;
    end else if (cmd.div_step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r + 5'd1;
    end
    if (cmd.out_load) begin
      out_bits_r <= emit_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      cur_r       <= ROOT_NODE;
      kind_r      <= ANIM_NONE;
      anode_r     <= 6'd0;
      astart_r    <= 32'd0;
      aphase_r    <= '1;
      map_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      if (cmd.op_show) begin
        kind_r <= ANIM_NONE;
        cur_r  <= node_r;
      end
      if (cmd.op_lock) begin
        anode_r  <= node_r;
        astart_r <= now_r;
        aphase_r <= '1;
        kind_r   <= style_r ? ANIM_BLINK : ANIM_HOLD;
      end
      if (cmd.op_error) begin
        kind_r   <= ANIM_ERR;
        astart_r <= now_r;
        aphase_r <= '1;
      end
      if (cmd.op_idle) begin
        kind_r <= ANIM_NONE;
      end
      if (cmd.op_end) begin
        kind_r <= ANIM_NONE;
        cur_r  <= ROOT_NODE;
      end
      if (cmd.set_phase) begin
        aphase_r <= quo_r;
      end
      if (map_we) begin
        map_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.action      = act_r;
    sts.kind        = kind_r;
    sts.style_blink = style_r;
    sts.hold_over   = elapsed >= {16'd0, hold_r};
    sts.blink_over  = elapsed >= {7'd0, total_r};
    sts.walk_skip   = !wsingle_r && (wnode_r == 6'd0);
    sts.walk_last   = wsingle_r || (wnode_r[5:1] == 5'd0);
    sts.div_last    = (dcnt_r == 5'd31);
    sts.phase_same  = (quo_r == aphase_r);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_led_bits = out_bits_r;
endmodule

// File: src/morse_tree_led_animator_unit.sv
`timescale 1ns / 1ps
// Top level of the Morse tree LED animator: controller, datapath and channel wiring.
//
// Items arrive on in_chan and are taken one at a time; a beat is accepted when
// valid and ready are both high. Each item may produce one LED frame beat on
// out_chan. Configuration registers are written through cfg_we, cfg_idx and
// cfg_wdata; the user must write them only while the block is idle, which the
// block itself does not enforce. Indexes beyond the register list are ignored.
// Show node and mode changes go through the path walk, which reads the node map
// once per tree level in path mode and once in single mode. A blink tick that
// changes phase passes through the 32-step bit-serial phase divider. The next
// item can be taken in the cycle after the previous one completes.
// The output frame sits in a register, so a new item is accepted while a frame
// still waits; if the receiver stalls, the block holds its next frame until the
// output register frees. Reset is synchronous and active low: it restores the
// register defaults, clears the node map to no LED and returns to single mode
// at the root with no animation.
module morse_tree_led_animator_unit #(
  parameter int NODE_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mtla_in_if.sink                        in_chan,
  mtla_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [mtla_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [63:0]                    cfg_wdata
);
  import mtla_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mtla_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_chan.valid),
    .in_ready(in_chan.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mtla_datapath #(
    .NODE_COUNT(NODE_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_chan.action),
    .in_node       (in_chan.node),
    .in_mode_path  (in_chan.mode_path),
    .in_now_ms     (in_chan.now_ms),
    .in_raw_bits   (in_chan.raw_bits),
    .in_map_led    (in_chan.map_led),
    .in_map_has_led(in_chan.map_has_led),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_led_bits  (out_chan.led_bits)
  );
endmodule

// File: tb/mtla_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard that tracks the animator state and checks every LED frame beat.
module mtla_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  mtla_in_if                             in_chan,
  mtla_out_if                            out_chan,
  input  logic                           cfg_we,
  input  logic [mtla_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [63:0]                    cfg_wdata,
  output int unsigned                    errors,
  output int unsigned                    pending,
  output int unsigned                    frames_checked
);
  import mtla_pkg::*;

  logic        blink_style;
  logic [15:0] hold_ms;
  logic [7:0]  lock_count;
  logic [15:0] lock_half;
  logic [7:0]  err_count;
  logic [15:0] err_half;
  logic [63:0] all_mask;

  logic        path_mode;
  logic [5:0]  cur_node;
  anim_t       anim_kind;
  logic [5:0]  anim_node;
  logic [31:0] anim_start;
  logic [31:0] anim_phase;
  logic [6:0]  node_map [64];

  logic [63:0] expected_frames [$];

  task automatic report(input string what);
    $display("%0t: LED frame mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic restore_defaults();
    blink_style = 1'b0;
    hold_ms     = 16'd500;
    lock_count  = 8'd3;
    lock_half   = 16'd100;
    err_count   = 8'd3;
    err_half    = 16'd100;
    all_mask    = '1;
    path_mode   = 1'b0;
    cur_node    = ROOT_NODE;
    anim_kind   = ANIM_NONE;
    anim_node   = '0;
    anim_start  = '0;
    anim_phase  = '1;
    foreach (node_map[i]) node_map[i] = '0;
  endtask

  task automatic take_reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    case (idx)
      CFG_LOCK_STYLE: blink_style = val[0];
      CFG_LOCK_HOLD:  hold_ms     = val[15:0];
      CFG_LOCK_COUNT: lock_count  = val[7:0];
      CFG_LOCK_HALF:  lock_half   = val[15:0];
      CFG_ERR_COUNT:  err_count   = val[7:0];
      CFG_ERR_HALF:   err_half    = val[15:0];
      CFG_ALL_LEDS:   all_mask    = val;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] node_led(input logic [5:0] nd);
    if (!node_map[nd][6]) return '0;
    return 64'd1 << node_map[nd][5:0];
  endfunction

  function automatic logic [63:0] node_frame(input logic [5:0] nd);
    logic [63:0] f;
    logic [5:0]  n;
    if (!path_mode) return node_led(nd);
    f = '0;
    n = nd;
    while (n != 0) begin
      f |= node_led(n);
      n = n >> 1;
    end
    return f;
  endfunction

  function automatic logic [63:0] back_to_root();
    anim_kind = ANIM_NONE;
    cur_node  = ROOT_NODE;
    return node_frame(ROOT_NODE);
  endfunction

  function automatic bit blink_frame(input logic [31:0] el, input logic [7:0] count,
                                     input logic [15:0] half, input logic [63:0] on_frame,
                                     output logic [63:0] frame);
    logic [31:0] total;
    logic [31:0] ph;
    frame = '0;
    total = {24'd0, count} * 32'd2 * {16'd0, half};
    if (el >= total) begin
      frame = back_to_root();
      return 1'b1;
    end
    ph = el / {16'd0, half};
    if (ph == anim_phase) return 1'b0;
    anim_phase = ph;
    frame = ph[0] ? '0 : on_frame;
    return 1'b1;
  endfunction

  function automatic bit apply_cmd(input logic [3:0] action, input logic [5:0] nd,
                                   input logic mp, input logic [31:0] now,
                                   input logic [63:0] raw, input logic [5:0] led,
                                   input logic has, output logic [63:0] frame);
    logic [31:0] el;
    el = now - anim_start;
    frame = '0;
    case (action)
      ACT_SHOW: begin
        anim_kind = ANIM_NONE;
        cur_node  = nd;
        frame     = node_frame(nd);
        return 1'b1;
      end
      ACT_SET_MODE, ACT_TOGGLE: begin
        path_mode = (action == ACT_SET_MODE) ? mp : !path_mode;
        if (anim_kind != ANIM_NONE) return 1'b0;
        frame = node_frame(cur_node);
        return 1'b1;
      end
      ACT_LOCK: begin
        anim_node  = nd;
        anim_start = now;
        anim_phase = '1;
        if (blink_style) begin
          anim_kind = ANIM_BLINK;
          return 1'b0;
        end
        anim_kind = ANIM_HOLD;
        frame     = node_led(nd);
        return 1'b1;
      end
      ACT_ERROR: begin
        anim_kind  = ANIM_ERR;
        anim_start = now;
        anim_phase = '1;
      end
      ACT_CANCEL: anim_kind = ANIM_NONE;
      ACT_RAW: begin
        anim_kind = ANIM_NONE;
        frame     = raw;
        return 1'b1;
      end
      ACT_TICK: begin
        case (anim_kind)
          ANIM_HOLD: begin
            if (el >= {16'd0, hold_ms}) begin
              frame = back_to_root();
              return 1'b1;
            end
          end
          ANIM_BLINK:
            return blink_frame(el, lock_count, lock_half, node_led(anim_node), frame);
          ANIM_ERR:
            return blink_frame(el, err_count, err_half, all_mask, frame);
          default: ;
        endcase
      end
      ACT_LOAD: node_map[nd] = {has, led};
      default: ;
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    logic [63:0] frame;
    logic [63:0] want;
    if (!rst_n) begin
      restore_defaults();
      expected_frames.delete();
      errors         = 0;
      frames_checked = 0;
    end else begin
      if (cfg_we) take_reg_write(cfg_idx, cfg_wdata);
      if (in_chan.valid && in_chan.ready) begin
        if (apply_cmd(in_chan.action, in_chan.node, in_chan.mode_path, in_chan.now_ms,
                      in_chan.raw_bits, in_chan.map_led, in_chan.map_has_led, frame))
          expected_frames.push_back(frame);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_frames.size() == 0) begin
          report($sformatf("frame %h arrived with none expected", out_chan.led_bits));
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (out_chan.led_bits !== want)
            report($sformatf("led_bits %h, expected %h", out_chan.led_bits, want));
        end
      end
    end
    pending = expected_frames.size();
  end

endmodule

// File: tb/morse_tree_led_animator_unit_tb.sv
`timescale 1ns / 1ps
// Top of the animator testbench: clock, reset, stimulus, output stalls and verdict.
module morse_tree_led_animator_unit_tb;
  import mtla_pkg::*;

  localparam int unsigned LIMIT_CYCLES      = 300000;
  localparam int unsigned SETTLE_CYCLES     = 100;
  localparam int unsigned LONG_STALL_CYCLES = 400;
  localparam logic [3:0]  ACT_FIRST_UNUSED  = 4'd9;
  localparam logic [3:0]  ACT_LAST_UNUSED   = 4'd15;

  typedef struct {
    logic [3:0]  action;
    logic [5:0]  node;
    logic        mode_path;
    logic [31:0] now_ms;
    logic [63:0] raw_bits;
    logic [5:0]  map_led;
    logic        map_has_led;
  } led_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [63:0]          cfg_wdata;

  int unsigned errors;
  int unsigned pending;
  int unsigned frames_checked;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned reg_settings = 0;

  bit          idle_on = 1'b1;
  bit          long_stall_req = 1'b0;
  logic [31:0] clock_ms;
  logic        lk_style;
  logic [15:0] lk_hold;
  logic [15:0] lk_half;
  logic [15:0] er_half;

  mtla_in_if  in_chan ();
  mtla_out_if out_chan ();

  morse_tree_led_animator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  mtla_frame_checker frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .errors         (errors),
    .pending        (pending),
    .frames_checked (frames_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("morse_tree_led_animator_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic led_cmd_t rand_cmd(input logic [3:0] act, input logic [5:0] nd,
                                        input logic [31:0] t);
    led_cmd_t c;
    c.action      = act;
    c.node        = nd;
    c.mode_path   = 1'($urandom_range(0, 1));
    c.now_ms      = t;
    c.raw_bits    = {$urandom, $urandom};
    c.map_led     = 6'($urandom);
    c.map_has_led = 1'($urandom_range(0, 1));
    return c;
  endfunction

  task automatic send_cmd(input led_cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= c.action;
    in_chan.node        <= c.node;
    in_chan.mode_path   <= c.mode_path;
    in_chan.now_ms      <= c.now_ms;
    in_chan.raw_bits    <= c.raw_bits;
    in_chan.map_led     <= c.map_led;
    in_chan.map_has_led <= c.map_has_led;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic load_entry(input logic [5:0] nd, input logic has, input logic [5:0] led);
    led_cmd_t c;
    c = rand_cmd(ACT_LOAD, nd, $urandom);
    c.map_has_led = has;
    c.map_led     = led;
    send_cmd(c);
  endtask

  task automatic set_mode(input logic mp);
    led_cmd_t c;
    c = rand_cmd(ACT_SET_MODE, 6'($urandom), $urandom);
    c.mode_path = mp;
    send_cmd(c);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic style, input logic [15:0] hold,
                              input logic [7:0] lcnt, input logic [15:0] lhalf,
                              input logic [7:0] ecnt, input logic [15:0] ehalf,
                              input logic [63:0] mask);
    put_reg(CFG_LOCK_STYLE, 64'(style));
    put_reg(CFG_LOCK_HOLD, 64'(hold));
    put_reg(CFG_LOCK_COUNT, 64'(lcnt));
    put_reg(CFG_LOCK_HALF, 64'(lhalf));
    put_reg(CFG_ERR_COUNT, 64'(ecnt));
    put_reg(CFG_ERR_HALF, 64'(ehalf));
    put_reg(CFG_ALL_LEDS, mask);
    cfg_we   <= 1'b0;
    lk_style = style;
    lk_hold  = hold;
    lk_half  = lhalf;
    er_half  = ehalf;
    reg_settings++;
  endtask

  // Waits until every expected frame has come back and the block has gone quiet.
  task automatic settle();
    in_chan.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    int unsigned span;
    logic [3:0]  start_act;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        if ($urandom_range(0, 1) == 1) begin
          start_act = ACT_LOCK;
          span      = lk_style ? 32'(lk_half) : 32'(lk_hold);
        end else begin
          start_act = ACT_ERROR;
          span      = 32'(er_half);
        end
        span = span + 1;
        send_cmd(rand_cmd(start_act, 6'($urandom), clock_ms));
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 9))
            0: clock_ms += $urandom;
            1: ;
            default: clock_ms += $urandom_range(0, span);
          endcase
          case ($urandom_range(0, 15))
            0: send_cmd(rand_cmd(ACT_SHOW, 6'($urandom), $urandom));
            1: set_mode(1'($urandom_range(0, 1)));
            2: send_cmd(rand_cmd(ACT_CANCEL, 6'($urandom), $urandom));
            3: send_cmd(rand_cmd(ACT_TOGGLE, 6'($urandom), $urandom));
            default: send_cmd(rand_cmd(ACT_TICK, 6'($urandom), clock_ms));
          endcase
        end
      end else if (pick < 55) begin
        send_cmd(rand_cmd(ACT_SHOW, 6'($urandom), $urandom));
      end else if (pick < 60) begin
        set_mode(1'($urandom_range(0, 1)));
      end else if (pick < 64) begin
        send_cmd(rand_cmd(ACT_TOGGLE, 6'($urandom), $urandom));
      end else if (pick < 78) begin
        load_entry(6'($urandom), $urandom_range(0, 3) != 0, 6'($urandom));
      end else if (pick < 84) begin
        send_cmd(rand_cmd(ACT_RAW, 6'($urandom), $urandom));
      end else if (pick < 89) begin
        send_cmd(rand_cmd(ACT_CANCEL, 6'($urandom), $urandom));
      end else if (pick < 96) begin
        send_cmd(rand_cmd(ACT_TICK, 6'($urandom), clock_ms));
      end else begin
        send_cmd(rand_cmd(4'($urandom_range(ACT_LAST_UNUSED, ACT_FIRST_UNUSED)),
                          6'($urandom), $urandom));
      end
      clock_ms += $urandom_range(0, 3);
    end
  endtask

  initial begin : stimulus
    led_cmd_t c;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_LOCK_STYLE;
    cfg_wdata           <= '0;
    in_chan.valid       <= 1'b0;
    in_chan.action      <= ACT_SHOW;
    in_chan.node        <= '0;
    in_chan.mode_path   <= 1'b0;
    in_chan.now_ms      <= '0;
    in_chan.raw_bits    <= '0;
    in_chan.map_led     <= '0;
    in_chan.map_has_led <= 1'b0;
    clock_ms = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    program_regs(1'b0, 16'd20, 8'd2, 16'd5, 8'd2, 16'd7, {$urandom, $urandom});
    load_entry(6'd1, 1'b1, 6'd0);
    load_entry(6'd2, 1'b1, 6'd5);
    load_entry(6'd5, 1'b1, 6'd10);
    load_entry(6'd11, 1'b0, 6'd33);
    load_entry(6'd22, 1'b1, 6'd22);
    load_entry(6'd45, 1'b1, 6'd63);
    load_entry(6'd0, 1'b1, 6'd42);
    load_entry(6'd63, 1'b1, 6'd62);
    send_cmd(rand_cmd(ACT_SHOW, 6'd1, $urandom));
    send_cmd(rand_cmd(ACT_SHOW, 6'd0, $urandom));
    send_cmd(rand_cmd(ACT_SHOW, 6'd63, $urandom));
    set_mode(1'b1);
    send_cmd(rand_cmd(ACT_SHOW, 6'd45, $urandom));
    send_cmd(rand_cmd(ACT_SHOW, 6'd0, $urandom));
    send_cmd(rand_cmd(ACT_TOGGLE, 6'($urandom), $urandom));
    c = rand_cmd(ACT_RAW, 6'($urandom), $urandom);
    c.raw_bits = '1;
    send_cmd(c);
    c.raw_bits = '0;
    send_cmd(c);
    // The hold window straddles the wrap of the millisecond counter.
    send_cmd(rand_cmd(ACT_LOCK, 6'd45, 32'hFFFF_FFF0));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), 32'hFFFF_FFFF));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), 32'd4));
    send_cmd(rand_cmd(ACT_ERROR, 6'($urandom), 32'd100));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), 32'd100));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), 32'd103));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), 32'd107));
    set_mode(1'b1);
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), 32'd128));
    send_cmd(rand_cmd(ACT_CANCEL, 6'($urandom), $urandom));
    send_cmd(rand_cmd(ACT_LAST_UNUSED, 6'($urandom), $urandom));
    settle();

    program_regs(1'b1, 16'd0, 8'd1, 16'd1, 8'd255, 16'hFFFF, 64'd0);
    run_random(120);
    settle();

    // With a zero blink length the first tick ends the animation.
    program_regs(1'b1, 16'd0, 8'd0, 16'd0, 8'd0, 16'd0, '1);
    send_cmd(rand_cmd(ACT_LOCK, 6'd45, clock_ms));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), clock_ms + 32'd1));
    send_cmd(rand_cmd(ACT_ERROR, 6'($urandom), clock_ms));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), clock_ms + 32'd5));
    settle();
    program_regs(1'b0, 16'd0, 8'd1, 16'd1, 8'd1, 16'd1, '1);
    send_cmd(rand_cmd(ACT_LOCK, 6'd45, clock_ms));
    send_cmd(rand_cmd(ACT_TICK, 6'($urandom), clock_ms));
    settle();

    program_regs(1'b0, 16'hFFFF, 8'd255, 16'hFFFF, 8'd1, 16'd1, {$urandom, $urandom});
    run_random(100);
    settle();

    program_regs(1'($urandom_range(0, 1)), 16'($urandom_range(1, 300)),
                 8'($urandom_range(1, 8)), 16'($urandom_range(1, 40)),
                 8'($urandom_range(1, 8)), 16'($urandom_range(1, 40)),
                 {$urandom, $urandom});
    long_stall_req = 1'b1;
    repeat (30) send_cmd(rand_cmd(ACT_SHOW, 6'($urandom), $urandom));
    run_random(90);
    idle_on = 1'b0;
    run_random(60);
    settle();

    $display("Run covered %0d input beats under %0d register settings,", items_sent,
             reg_settings);
    $display("with one long output stall; %0d LED frames were compared.", frames_checked);
    if (errors == 0) begin
      $display("morse_tree_led_animator_unit_tb: clean");
    end else begin
      $display("morse_tree_led_animator_unit_tb: errors");
    end
    $finish;
  end

endmodule

// File: morse_tree_led_animator_unit.f
src/mtla_pkg.sv
src/mtla_if.sv
src/mtla_ram.sv
src/mtla_ctrl.sv
src/mtla_datapath.sv
src/morse_tree_led_animator_unit.sv
tb/mtla_frame_checker.sv
tb/morse_tree_led_animator_unit_tb.sv
